/* hw/rtl/assert_macros.svh */
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/svm_pkg.sv */
// shared types and constants of the stack machine executor
`default_nettype none
package svm_pkg;
    localparam logic [5:0] OP_LEA  = 6'd0;
    localparam logic [5:0] OP_IMM  = 6'd1;
    localparam logic [5:0] OP_JMP  = 6'd2;
    localparam logic [5:0] OP_CALL = 6'd3;
    localparam logic [5:0] OP_JZ   = 6'd4;
    localparam logic [5:0] OP_JNZ  = 6'd5;
    localparam logic [5:0] OP_ENT  = 6'd6;
    localparam logic [5:0] OP_ADJ  = 6'd7;
    localparam logic [5:0] OP_LEV  = 6'd8;
    localparam logic [5:0] OP_LI   = 6'd9;
    localparam logic [5:0] OP_LC   = 6'd10;
    localparam logic [5:0] OP_SI   = 6'd11;
    localparam logic [5:0] OP_SC   = 6'd12;
    localparam logic [5:0] OP_PUSH = 6'd13;
    localparam logic [5:0] OP_OR   = 6'd14;
    localparam logic [5:0] OP_XOR  = 6'd15;
    localparam logic [5:0] OP_AND  = 6'd16;
    localparam logic [5:0] OP_EQ   = 6'd17;
    localparam logic [5:0] OP_NE   = 6'd18;
    localparam logic [5:0] OP_LT   = 6'd19;
    localparam logic [5:0] OP_GT   = 6'd20;
    localparam logic [5:0] OP_LE   = 6'd21;
    localparam logic [5:0] OP_GE   = 6'd22;
    localparam logic [5:0] OP_SHL  = 6'd23;
    localparam logic [5:0] OP_SHR  = 6'd24;
    localparam logic [5:0] OP_ADD  = 6'd25;
    localparam logic [5:0] OP_SUB  = 6'd26;
    localparam logic [5:0] OP_MUL  = 6'd27;
    localparam logic [5:0] OP_DIV  = 6'd28;
    localparam logic [5:0] OP_MOD  = 6'd29;
    localparam logic [5:0] OP_EXIT = 6'd37;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_HALT   = 2'd1;
    localparam logic [1:0] ST_BADOP  = 2'd2;
    localparam logic [1:0] ST_DIVZ   = 2'd3;

    // memory port address select
    typedef enum logic [1:0] {
        MA_SP   = 2'd0,  // word at sp
        MA_ACC  = 2'd1,  // word at accumulator
        MA_TMP  = 2'd2,  // word at popped address
        MA_FP   = 2'd3   // word at fp
    } t_maddr;

    // commands from controller to datapath
    typedef struct packed {
        logic   clr_en;    // clearing sweep write
        logic   mem_rd;    // issue read
        t_maddr rd_sel;
        logic   cap_pop;   // latch read data into temp, sp += 4 (fp + 4 for lev)
        logic   exec;      // run the instruction's final step
        logic   div_go;    // start divider
        logic   out_load;  // load result registers
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic halted;
    } t_stat;
endpackage
`default_nettype wire

/* hw/rtl/svm_ram.sv */
// generic single port ram with registered read
`default_nettype none
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/svm_div.sv */
// iterative signed divider, one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module svm_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output      logic        o_busy,
    output      logic [31:0] o_quo,
    output      logic [31:0] o_rem
);
    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    logic [31:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d, n_d;
    logic        r_qneg, n_qneg;
    logic        r_rneg, n_rneg;
    logic [32:0] w_sh;
    logic [32:0] w_diff;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        n_qneg = r_qneg;
        n_rneg = r_rneg;
        w_sh   = {r_r[31:0], r_q[31]};
        w_diff = w_sh - {1'b0, r_d};
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = 6'd32;
            n_q    = i_num[31] ? (~i_num + 32'd1) : i_num;
            n_d    = i_den[31] ? (~i_den + 32'd1) : i_den;
            n_r    = '0;
            n_qneg = i_num[31] ^ i_den[31];
            n_rneg = i_num[31];
        end else if (r_busy) begin
            if (!w_diff[32]) begin
                n_r = w_diff;
                n_q = {r_q[30:0], 1'b1};
            end else begin
                n_r = w_sh;
                n_q = {r_q[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q    <= n_q;
        r_r    <= n_r;
        r_d    <= n_d;
        r_qneg <= n_qneg;
        r_rneg <= n_rneg;
    end

    assign o_busy = r_busy;
    assign o_quo  = r_qneg ? (~r_q + 32'd1) : r_q;
    assign o_rem  = r_rneg ? (~r_r[31:0] + 32'd1) : r_r[31:0];

    `ASSERT_IMP(a_cnt_busy, i_clk, i_rst_n, r_busy, r_cnt != 6'd0)
    `ASSERT_NEXT(a_go_busy, i_clk, i_rst_n, i_go, r_busy)
endmodule
`default_nettype wire

/* hw/rtl/svm_datapath.sv */
// architectural registers, stack memory and alu of the stack machine
`default_nettype none
module svm_datapath #(
    parameter int MEMORY_WORDS = 16384,
    parameter int TEXT_WORDS   = 16384
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire svm_pkg::t_cmd   i_cmd,
    input  wire logic [5:0]      i_operation,
    input  wire logic [31:0]     i_operand,
    output      svm_pkg::t_stat  o_stat,
    output      logic [13:0]     o_next_pc,
    output      logic [31:0]     o_accumulator,
    output      logic [1:0]      o_status,
    output      logic [31:0]     o_exit_code
);
    localparam int AW = $clog2(MEMORY_WORDS);
    localparam int PW = $clog2(TEXT_WORDS);
    localparam logic [31:0] MEM_BYTES = 32'(MEMORY_WORDS) * 32'd4;

    logic [PW-1:0] r_pc;
    logic [31:0]   r_acc, r_sp, r_fp, r_tmp;
    logic          r_halted;
    logic [AW-1:0] r_clr;
    logic          r_clr_done;
    logic [31:0]   r_rd_addr;

    logic [31:0]   w_rdata;
    logic          w_we;
    logic [AW-1:0] w_addr;
    logic [31:0]   w_wdata;
    logic [31:0]   w_rd_addr;
    logic          w_div_busy;
    logic [31:0]   w_quo, w_rem;

    logic [PW-1:0] n_pc;
    logic [31:0]   n_acc, n_sp, n_fp;
    logic [1:0]    n_status;
    logic [31:0]   n_code;
    logic          n_halted;
    logic          w_wr;
    logic [31:0]   w_wr_addr, w_wr_data;

    logic [PW-1:0] w_next, w_after, w_imm_pc;
    logic [4:0]    w_sh;
    logic [4:0]    w_bsh;
    logic [31:0]   w_b;
    logic [31:0]   w_bmask;
    logic [63:0]   w_prod;
    logic signed [31:0] w_x, w_y;

    // word index of a byte address, wrapped to memory size
    function automatic logic [AW-1:0] widx(input logic [31:0] a);
        logic [31:0] m;
        m = a % MEM_BYTES;
        return m[AW+1:2];
    endfunction

    always_comb begin
        case (i_cmd.rd_sel)
            svm_pkg::MA_SP:  w_rd_addr = r_sp;
            svm_pkg::MA_ACC: w_rd_addr = r_acc;
            svm_pkg::MA_TMP: w_rd_addr = r_tmp;
            svm_pkg::MA_FP:  w_rd_addr = r_fp;
            default:         w_rd_addr = r_sp;
        endcase
    end

    assign w_next   = r_pc + PW'(1);
    assign w_after  = r_pc + PW'(2);
    assign w_imm_pc = PW'(i_operand % TEXT_WORDS);
    assign w_sh     = r_acc[4:0];
    assign w_x      = r_tmp;
    assign w_y      = r_acc;
    assign w_bsh    = {r_rd_addr[1:0], 3'b000};
    assign w_b      = w_rdata >> w_bsh;
    assign w_bmask  = ~(32'hFF << w_bsh);
    assign w_prod   = 64'(r_tmp) * 64'(r_acc);

    always_comb begin
        n_pc      = w_next;
        n_acc     = r_acc;
        n_sp      = r_sp;
        n_fp      = r_fp;
        n_status  = svm_pkg::ST_OK;
        n_code    = '0;
        n_halted  = r_halted;
        w_wr      = 1'b0;
        w_wr_addr = r_sp;
        w_wr_data = r_acc;
        if (r_halted) begin
            n_pc     = r_pc;
            n_status = svm_pkg::ST_HALT;
            n_code   = w_rdata;
        end else begin
            case (i_operation)
                svm_pkg::OP_LEA: begin
                    n_acc = r_fp + (i_operand << 2);
                    n_pc  = w_after;
                end
                svm_pkg::OP_IMM: begin
                    n_acc = i_operand;
                    n_pc  = w_after;
                end
                svm_pkg::OP_JMP: n_pc = w_imm_pc;
                svm_pkg::OP_CALL: begin
                    n_sp      = r_sp - 32'd4;
                    w_wr      = 1'b1;
                    w_wr_addr = r_sp - 32'd4;
                    w_wr_data = 32'(w_after);
                    n_pc      = w_imm_pc;
                end
                svm_pkg::OP_JZ:  n_pc = (r_acc != 0) ? w_after : w_imm_pc;
                svm_pkg::OP_JNZ: n_pc = (r_acc != 0) ? w_imm_pc : w_after;
                svm_pkg::OP_ENT: begin
                    w_wr      = 1'b1;
                    w_wr_addr = r_sp - 32'd4;
                    w_wr_data = r_fp;
                    n_fp      = r_sp - 32'd4;
                    n_sp      = r_sp - 32'd4 - (i_operand << 2);
                    n_pc      = w_after;
                end
                svm_pkg::OP_ADJ: begin
                    n_sp = r_sp + (i_operand << 2);
                    n_pc = w_after;
                end
                svm_pkg::OP_LEV: begin
                    // tmp holds saved fp, rdata the return address
                    n_fp = r_tmp;
                    n_sp = r_fp + 32'd8;
                    n_pc = PW'(w_rdata % TEXT_WORDS);
                end
                svm_pkg::OP_LI: n_acc = w_rdata;
                svm_pkg::OP_LC: n_acc = {{24{w_b[7]}}, w_b[7:0]};
                svm_pkg::OP_SI: begin
                    w_wr      = 1'b1;
                    w_wr_addr = r_tmp;
                    w_wr_data = r_acc;
                end
                svm_pkg::OP_SC: begin
                    w_wr      = 1'b1;
                    w_wr_addr = r_rd_addr;
                    w_wr_data = (w_rdata & w_bmask) | ({24'd0, r_acc[7:0]} << w_bsh);
                    n_acc     = {{24{r_acc[7]}}, r_acc[7:0]};
                end
                svm_pkg::OP_PUSH: begin
                    n_sp      = r_sp - 32'd4;
                    w_wr      = 1'b1;
                    w_wr_addr = r_sp - 32'd4;
                end
                svm_pkg::OP_EXIT: begin
                    n_halted = 1'b1;
                    n_pc     = r_pc;
                    n_status = svm_pkg::ST_HALT;
                    n_code   = w_rdata;
                end
                svm_pkg::OP_OR:  n_acc = r_tmp | r_acc;
                svm_pkg::OP_XOR: n_acc = r_tmp ^ r_acc;
                svm_pkg::OP_AND: n_acc = r_tmp & r_acc;
                svm_pkg::OP_EQ:  n_acc = 32'(w_x == w_y);
                svm_pkg::OP_NE:  n_acc = 32'(w_x != w_y);
                svm_pkg::OP_LT:  n_acc = 32'(w_x < w_y);
                svm_pkg::OP_GT:  n_acc = 32'(w_x > w_y);
                svm_pkg::OP_LE:  n_acc = 32'(w_x <= w_y);
                svm_pkg::OP_GE:  n_acc = 32'(w_x >= w_y);
                svm_pkg::OP_SHL: n_acc = r_tmp << w_sh;
                svm_pkg::OP_SHR: n_acc = 32'(w_x >>> w_sh);
                svm_pkg::OP_ADD: n_acc = r_tmp + r_acc;
                svm_pkg::OP_SUB: n_acc = r_tmp - r_acc;
                svm_pkg::OP_MUL: n_acc = w_prod[31:0];
                svm_pkg::OP_DIV, svm_pkg::OP_MOD: begin
                    if (r_acc == 0) begin
                        n_acc    = '1;
                        n_status = svm_pkg::ST_DIVZ;
                    end else if (i_operation == svm_pkg::OP_DIV) begin
                        n_acc = w_quo;
                    end else begin
                        n_acc = w_rem;
                    end
                end
                default: n_status = svm_pkg::ST_BADOP;
            endcase
        end
    end

    // single memory port: clear sweep, final write, else read
    always_comb begin
        w_we    = 1'b0;
        w_addr  = widx(w_rd_addr);
        w_wdata = w_wr_data;
        if (i_cmd.clr_en) begin
            w_we    = 1'b1;
            w_addr  = r_clr;
            w_wdata = '0;
        end else if (i_cmd.exec && w_wr) begin
            w_we   = 1'b1;
            w_addr = widx(w_wr_addr);
        end
    end

    svm_ram #(.WIDTH(32), .DEPTH(MEMORY_WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    svm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (i_cmd.div_go),
        .i_num  (r_tmp),
        .i_den  (r_acc),
        .o_busy (w_div_busy),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= '0;
            r_acc      <= '0;
            r_sp       <= MEM_BYTES;
            r_fp       <= MEM_BYTES;
            r_halted   <= 1'b0;
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + AW'(1);
                if (r_clr == AW'(MEMORY_WORDS - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cmd.cap_pop) begin
                // lev pops its saved fp from the frame, so sp moves past the frame
                r_sp <= ((i_operation == svm_pkg::OP_LEV) ? r_fp : r_sp) + 32'd4;
            end
            if (i_cmd.exec) begin
                r_pc     <= n_pc;
                r_acc    <= n_acc;
                r_halted <= n_halted;
                r_fp     <= n_fp;
                if (!i_cmd.cap_pop) begin
                    r_sp <= n_sp;
                end
            end
        end
        if (i_cmd.mem_rd) begin
            r_rd_addr <= w_rd_addr;
        end
        if (i_cmd.cap_pop) begin
            r_tmp <= w_rdata;
        end
        if (i_cmd.out_load) begin
            o_next_pc     <= 14'(n_pc);
            o_accumulator <= n_acc;
            o_status      <= n_status;
            o_exit_code   <= n_code;
        end
    end

    assign o_stat = '{clr_done: r_clr_done, div_busy: w_div_busy, halted: r_halted};
endmodule
`default_nettype wire

/* hw/rtl/svm_ctrl.sv */
// instruction sequencer of the stack machine
`default_nettype none
`include "assert_macros.svh"
module svm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output      logic           o_ready,
    input  wire logic [5:0]     i_operation,
    output      logic           o_valid,
    input  wire logic           i_ready,
    input  wire svm_pkg::t_stat i_stat,
    output      svm_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RD1   = 8'b00000100,  // first read issued
        S_RD2   = 8'b00001000,  // second read issued
        S_DIV   = 8'b00010000,
        S_EXEC  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_WAIT  = 8'b10000000
    } t_state;

    t_state          r_state, n_state;
    logic [5:0]      r_op, n_op;
    logic            r_oval, n_oval;
    logic            w_pop_op, w_two_rd, w_div_op;
    svm_pkg::t_maddr w_hold_sel;

    // opcodes whose first read is a stack pop
    assign w_pop_op = (r_op >= svm_pkg::OP_OR && r_op <= svm_pkg::OP_MOD)
                   || r_op == svm_pkg::OP_SI || r_op == svm_pkg::OP_SC
                   || r_op == svm_pkg::OP_LEV;
    // opcodes that need a second read after the pop
    assign w_two_rd = r_op == svm_pkg::OP_SC || r_op == svm_pkg::OP_LEV;
    assign w_div_op = r_op == svm_pkg::OP_DIV || r_op == svm_pkg::OP_MOD;

    // address that keeps the final step's read data in place
    assign w_hold_sel = i_stat.halted ? svm_pkg::MA_SP
                      : (r_op == svm_pkg::OP_LI || r_op == svm_pkg::OP_LC) ? svm_pkg::MA_ACC
                      : (r_op == svm_pkg::OP_SC) ? svm_pkg::MA_TMP : svm_pkg::MA_SP;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_oval  = r_oval;
        o_cmd   = '{clr_en: 1'b0, mem_rd: 1'b0, rd_sel: svm_pkg::MA_SP,
                    cap_pop: 1'b0, exec: 1'b0, div_go: 1'b0, out_load: 1'b0};
        o_ready = 1'b0;
        if (r_oval && i_ready) begin
            n_oval = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_done) begin
                    o_cmd.clr_en = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op    = i_operation;
                    n_state = S_RD1;
                    o_cmd.mem_rd = 1'b1;
                    o_cmd.rd_sel = i_stat.halted ? svm_pkg::MA_SP
                                 : (i_operation == svm_pkg::OP_LEV) ? svm_pkg::MA_FP
                                 : (i_operation == svm_pkg::OP_LI
                                    || i_operation == svm_pkg::OP_LC)
                                   ? svm_pkg::MA_ACC : svm_pkg::MA_SP;
                end
            end
            S_RD1: begin
                if (w_pop_op && !i_stat.halted) begin
                    o_cmd.cap_pop = 1'b1;
                    if (w_two_rd) begin
                        o_cmd.mem_rd = 1'b1;
                        o_cmd.rd_sel = (r_op == svm_pkg::OP_LEV)
                                     ? svm_pkg::MA_FP : svm_pkg::MA_TMP;
                        n_state = S_RD2;
                    end else if (w_div_op) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_EXEC;
                    end
                end else begin
                    o_cmd.rd_sel = w_hold_sel;
                    n_state = S_EXEC;
                end
            end
            S_RD2: begin
                // issue second read with latched address
                o_cmd.mem_rd = 1'b1;
                o_cmd.rd_sel = (r_op == svm_pkg::OP_LEV) ? svm_pkg::MA_SP : svm_pkg::MA_TMP;
                n_state = S_EXEC;
            end
            S_DIV: begin
                o_cmd.div_go = 1'b1;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.rd_sel = w_hold_sel;
                if (!r_oval || i_ready) begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_oval  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
        r_op <= n_op;
    end

    assign o_valid = r_oval;

    `ASSERT_IMP(a_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_state))
    `ASSERT_IMP(a_exec_out, i_clk, i_rst_n, o_cmd.exec, o_cmd.out_load)
endmodule
`default_nettype wire

/* hw/rtl/stack_vm_instruction_executor.sv */
// top level of the stack machine instruction executor
// usage:
//   input channel: i_valid/o_ready with i_operation and i_operand, the
//   opcode and following word fetched at the last reported next pc
//   output channel: o_valid/i_ready with o_next_pc, o_accumulator,
//   o_status and o_exit_code, one result per instruction
//   steps: the first read is issued as the instruction is accepted, then
//   the final step; sc and lev add a second read through the single port
//   stack memory with registered read, div and mod the 32 step divider
//   throughput: one instruction at a time, next accepted the cycle after
//   its result is loaded
//   reset: a clearing sweep zeroes the memory while o_ready stays low
//   stall: a result waits in the output registers; the next instruction is
//   accepted and worked on, and only its final step waits for the transfer
`default_nettype none
module stack_vm_instruction_executor #(
    parameter int MEMORY_WORDS = 16384,
    parameter int TEXT_WORDS   = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output      logic        o_ready,
    input  wire logic [5:0]  i_operation,
    input  wire logic [31:0] i_operand,
    output      logic        o_valid,
    input  wire logic        i_ready,
    output      logic [13:0] o_next_pc,
    output      logic [31:0] o_accumulator,
    output      logic [1:0]  o_status,
    output      logic [31:0] o_exit_code
);
    svm_pkg::t_cmd  w_cmd;
    svm_pkg::t_stat w_stat;
    logic [5:0]     r_op;
    logic [31:0]    r_operand;

    // hold the instruction for the whole execution
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op      <= i_operation;
            r_operand <= i_operand;
        end
    end

    svm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_operation(i_operation),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    svm_datapath #(.MEMORY_WORDS(MEMORY_WORDS), .TEXT_WORDS(TEXT_WORDS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_operation  (r_op),
        .i_operand    (r_operand),
        .o_stat       (w_stat),
        .o_next_pc    (o_next_pc),
        .o_accumulator(o_accumulator),
        .o_status     (o_status),
        .o_exit_code  (o_exit_code)
    );
endmodule
`default_nettype wire
